// ----- rtl/core/mdeu_pkg.sv -----
`timescale 1ns / 1ps

package mdeu_pkg;

	localparam int unsigned XLEN = 32;
	localparam int unsigned REG_W = 5;

	localparam logic [5:0] OP_SPECIAL = 6'h00;
	localparam logic [5:0] OP_J       = 6'h02;
	localparam logic [5:0] OP_JAL     = 6'h03;
	localparam logic [5:0] OP_BEQ     = 6'h04;
	localparam logic [5:0] OP_BNE     = 6'h05;
	localparam logic [5:0] OP_ADDI    = 6'h08;
	localparam logic [5:0] OP_ADDIU   = 6'h09;
	localparam logic [5:0] OP_SLTI    = 6'h0a;
	localparam logic [5:0] OP_SLTIU   = 6'h0b;
	localparam logic [5:0] OP_ANDI    = 6'h0c;
	localparam logic [5:0] OP_ORI     = 6'h0d;
	localparam logic [5:0] OP_LUI     = 6'h0f;
	localparam logic [5:0] OP_LW      = 6'h23;
	localparam logic [5:0] OP_SW      = 6'h2b;
	localparam logic [5:0] OP_LL      = 6'h30;

	localparam logic [5:0] FN_SLL  = 6'h00;
	localparam logic [5:0] FN_SRL  = 6'h02;
	localparam logic [5:0] FN_JR   = 6'h08;
	localparam logic [5:0] FN_ADD  = 6'h20;
	localparam logic [5:0] FN_ADDU = 6'h21;
	localparam logic [5:0] FN_SUB  = 6'h22;
	localparam logic [5:0] FN_SUBU = 6'h23;
	localparam logic [5:0] FN_AND  = 6'h24;
	localparam logic [5:0] FN_OR   = 6'h25;
	localparam logic [5:0] FN_NOR  = 6'h27;
	localparam logic [5:0] FN_SLT  = 6'h2a;
	localparam logic [5:0] FN_SLTU = 6'h2b;

	typedef enum logic [3:0] {
		ALU_NONE,
		ALU_ADD,
		ALU_SUB,
		ALU_AND,
		ALU_OR,
		ALU_NOR,
		ALU_SLT,
		ALU_SLTU,
		ALU_SLL,
		ALU_SRL,
		ALU_PASS,
		ALU_ADDR
	} alu_op_t;

	typedef enum logic [2:0] {
		BR_NONE,
		BR_EQ,
		BR_NE,
		BR_JUMP,
		BR_REG
	} br_op_t;

	typedef struct packed {
		alu_op_t          alu_op;
		br_op_t           br_op;
		logic [REG_W-1:0] dest;
		logic             reg_write;
		logic             mem_read;
		logic             mem_write;
		logic             mem_to_reg;
		logic             illegal;
	} ctrl_t;

endpackage

// ----- rtl/core/mips_decode_execute_unit.sv -----
`timescale 1ns / 1ps
// An accepted input word passes the decode, execute and result-select registers in order.
// Throughput: one word per cycle; a new word is taken in every cycle while the
// result side keeps taking words, and bubbles close up while the output stalls.
// The depth is set by the decode, execute and result-select register stages.
// Reset clears the stage valid bits only; payload registers are not reset.

module mips_decode_execute_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] instruction,
	input  logic [31:0] source_value,
	input  logic [31:0] target_value,
	input  logic [31:0] next_pc,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] alu_result,
	output logic [4:0]  dest_reg,
	output logic        reg_write,
	output logic        mem_read,
	output logic        mem_write,
	output logic        mem_to_reg,
	output logic        redirect,
	output logic [31:0] target_address,
	output logic        illegal
);

	logic ready_s1, ready_s2, ready_s3;
	logic valid_s1, valid_s2, valid_s3;

	// Decode.
	logic [5:0]  op, fn;
	logic [31:0] simm, zimm;
	mdeu_pkg::ctrl_t ctrl_d;
	logic [31:0] opb_d;

	assign op   = instruction[31:26];
	assign fn   = instruction[5:0];
	assign zimm = {16'b0, instruction[15:0]};
	assign simm = {{16{instruction[15]}}, instruction[15:0]};

	always_comb begin
		ctrl_d            = '0;
		ctrl_d.alu_op     = mdeu_pkg::ALU_NONE;
		ctrl_d.br_op      = mdeu_pkg::BR_NONE;
		ctrl_d.dest       = instruction[20:16];
		opb_d             = simm;
		case (op)
			mdeu_pkg::OP_SPECIAL: begin
				ctrl_d.dest      = instruction[15:11];
				ctrl_d.reg_write = 1'b1;
				opb_d            = target_value;
				case (fn)
					mdeu_pkg::FN_ADD, mdeu_pkg::FN_ADDU: ctrl_d.alu_op = mdeu_pkg::ALU_ADD;
					mdeu_pkg::FN_SUB, mdeu_pkg::FN_SUBU: ctrl_d.alu_op = mdeu_pkg::ALU_SUB;
					mdeu_pkg::FN_AND:  ctrl_d.alu_op = mdeu_pkg::ALU_AND;
					mdeu_pkg::FN_OR:   ctrl_d.alu_op = mdeu_pkg::ALU_OR;
					mdeu_pkg::FN_NOR:  ctrl_d.alu_op = mdeu_pkg::ALU_NOR;
					mdeu_pkg::FN_SLT:  ctrl_d.alu_op = mdeu_pkg::ALU_SLT;
					mdeu_pkg::FN_SLTU: ctrl_d.alu_op = mdeu_pkg::ALU_SLTU;
					mdeu_pkg::FN_SLL:  ctrl_d.alu_op = mdeu_pkg::ALU_SLL;
					mdeu_pkg::FN_SRL:  ctrl_d.alu_op = mdeu_pkg::ALU_SRL;
					mdeu_pkg::FN_JR: begin
						ctrl_d.reg_write = 1'b0;
						ctrl_d.br_op     = mdeu_pkg::BR_REG;
					end
					default: ctrl_d.illegal = 1'b1;
				endcase
			end
			mdeu_pkg::OP_ADDI, mdeu_pkg::OP_ADDIU: begin
				ctrl_d.reg_write = 1'b1;
				ctrl_d.alu_op    = mdeu_pkg::ALU_ADD;
			end
			mdeu_pkg::OP_ANDI: begin
				ctrl_d.reg_write = 1'b1;
				ctrl_d.alu_op    = mdeu_pkg::ALU_AND;
				opb_d            = zimm;
			end
			mdeu_pkg::OP_ORI: begin
				ctrl_d.reg_write = 1'b1;
				ctrl_d.alu_op    = mdeu_pkg::ALU_OR;
				opb_d            = zimm;
			end
			mdeu_pkg::OP_SLTI: begin
				ctrl_d.reg_write = 1'b1;
				ctrl_d.alu_op    = mdeu_pkg::ALU_SLT;
			end
			mdeu_pkg::OP_SLTIU: begin
				ctrl_d.reg_write = 1'b1;
				ctrl_d.alu_op    = mdeu_pkg::ALU_SLTU;
			end
			mdeu_pkg::OP_LUI: begin
				ctrl_d.reg_write = 1'b1;
				ctrl_d.alu_op    = mdeu_pkg::ALU_PASS;
				opb_d            = {instruction[15:0], 16'b0};
			end
			mdeu_pkg::OP_LW, mdeu_pkg::OP_LL: begin
				ctrl_d.reg_write  = 1'b1;
				ctrl_d.mem_read   = 1'b1;
				ctrl_d.mem_to_reg = 1'b1;
				ctrl_d.alu_op     = mdeu_pkg::ALU_ADDR;
			end
			mdeu_pkg::OP_SW: begin
				ctrl_d.mem_write = 1'b1;
				ctrl_d.alu_op    = mdeu_pkg::ALU_ADDR;
			end
			mdeu_pkg::OP_BEQ: begin
				ctrl_d.br_op = mdeu_pkg::BR_EQ;
				opb_d        = target_value;
			end
			mdeu_pkg::OP_BNE: begin
				ctrl_d.br_op = mdeu_pkg::BR_NE;
				opb_d        = target_value;
			end
			mdeu_pkg::OP_J, mdeu_pkg::OP_JAL: ctrl_d.br_op = mdeu_pkg::BR_JUMP;
			default: ctrl_d.illegal = 1'b1;
		endcase
		if (ctrl_d.illegal) begin
			ctrl_d         = '0;
			ctrl_d.alu_op  = mdeu_pkg::ALU_NONE;
			ctrl_d.br_op   = mdeu_pkg::BR_NONE;
			ctrl_d.illegal = 1'b1;
		end
	end

	// Stage handshakes: each stage moves when it is empty or the next one moves.
	assign ready_s3 = !valid_s3 || out_ready;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;

	// Stage 1: decoded word.
	mdeu_pkg::ctrl_t ctrl_s1;
	logic [31:0] opa_s1, opb_s1, npc_s1, boff_s1;
	logic [4:0]  shamt_s1;
	logic [25:0] jidx_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && ready_s1) begin
			ctrl_s1  <= ctrl_d;
			opa_s1   <= source_value;
			opb_s1   <= opb_d;
			npc_s1   <= next_pc;
			boff_s1  <= {simm[29:0], 2'b00};
			shamt_s1 <= instruction[10:6];
			jidx_s1  <= instruction[25:0];
		end
	end

	// Stage 2: adders, compare, logic and shift.
	mdeu_pkg::ctrl_t ctrl_s2;
	logic [31:0] sum_s2, misc_s2, btgt_s2, jtgt_s2, opa_s2;
	logic [32:0] diff_s2;
	logic        sgn_x_s2, eq_s2;
	logic [31:0] misc_d;

	always_comb begin
		case (ctrl_s1.alu_op)
			mdeu_pkg::ALU_AND:  misc_d = opa_s1 & opb_s1;
			mdeu_pkg::ALU_OR:   misc_d = opa_s1 | opb_s1;
			mdeu_pkg::ALU_NOR:  misc_d = ~(opa_s1 | opb_s1);
			mdeu_pkg::ALU_SLL:  misc_d = opb_s1 << shamt_s1;
			mdeu_pkg::ALU_SRL:  misc_d = opb_s1 >> shamt_s1;
			default:            misc_d = opb_s1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && ready_s2) begin
			ctrl_s2  <= ctrl_s1;
			sum_s2   <= opa_s1 + opb_s1;
			diff_s2  <= {1'b0, opa_s1} - {1'b0, opb_s1};
			sgn_x_s2 <= opa_s1[31] ^ opb_s1[31];
			eq_s2    <= (opa_s1 == opb_s1);
			misc_s2  <= misc_d;
			btgt_s2  <= npc_s1 + boff_s1;
			jtgt_s2  <= {npc_s1[31:28], jidx_s1, 2'b00};
			opa_s2   <= opa_s1;
		end
	end

	// Stage 3: result select and redirect resolution.
	logic [31:0] res_d, tgt_d;
	logic        redir_d;

	always_comb begin
		case (ctrl_s2.alu_op)
			mdeu_pkg::ALU_ADD:  res_d = sum_s2;
			mdeu_pkg::ALU_SUB:  res_d = diff_s2[31:0];
			mdeu_pkg::ALU_SLT:  res_d = {31'b0, diff_s2[32] ^ sgn_x_s2};
			mdeu_pkg::ALU_SLTU: res_d = {31'b0, diff_s2[32]};
			mdeu_pkg::ALU_ADDR: res_d = {2'b00, sum_s2[31:2]};
			mdeu_pkg::ALU_AND, mdeu_pkg::ALU_OR, mdeu_pkg::ALU_NOR,
			mdeu_pkg::ALU_SLL, mdeu_pkg::ALU_SRL,
			mdeu_pkg::ALU_PASS: res_d = misc_s2;
			default:            res_d = '0;
		endcase
		redir_d = 1'b0;
		tgt_d   = '0;
		case (ctrl_s2.br_op)
			mdeu_pkg::BR_EQ: begin
				redir_d = eq_s2;
				tgt_d   = eq_s2 ? btgt_s2 : '0;
			end
			mdeu_pkg::BR_NE: begin
				redir_d = !eq_s2;
				tgt_d   = eq_s2 ? '0 : btgt_s2;
			end
			mdeu_pkg::BR_JUMP: begin
				redir_d = 1'b1;
				tgt_d   = jtgt_s2;
			end
			mdeu_pkg::BR_REG: begin
				redir_d = 1'b1;
				tgt_d   = opa_s2;
			end
			default: begin
				redir_d = 1'b0;
				tgt_d   = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (ready_s3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2 && ready_s3) begin
			alu_result     <= res_d;
			dest_reg       <= ctrl_s2.dest;
			reg_write      <= ctrl_s2.reg_write;
			mem_read       <= ctrl_s2.mem_read;
			mem_write      <= ctrl_s2.mem_write;
			mem_to_reg     <= ctrl_s2.mem_to_reg;
			redirect       <= redir_d;
			target_address <= tgt_d;
			illegal        <= ctrl_s2.illegal;
		end
	end

	assign out_valid = valid_s3;

endmodule

// ----- rtl/core/mdeu_checker.sv -----
`timescale 1ns / 1ps

module mdeu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] alu_result,
	input logic [4:0]  dest_reg,
	input logic        reg_write,
	input logic        mem_read,
	input logic        mem_write,
	input logic        mem_to_reg,
	input logic        redirect,
	input logic [31:0] target_address,
	input logic        illegal
);

	// An illegal word carries nothing else.
	a_illegal_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && illegal |-> alu_result == 32'b0 && dest_reg == 5'b0 && !reg_write
			&& !mem_read && !mem_write && !mem_to_reg && !redirect
			&& target_address == 32'b0)
		else $error("illegal word with nonzero fields");

	a_target_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !redirect |-> target_address == 32'b0)
		else $error("target set without redirect");

	a_mem_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (mem_to_reg == mem_read) && !(mem_write && (reg_write || mem_read))
			&& !(redirect && (reg_write || mem_read || mem_write)))
		else $error("inconsistent control flags");

	// A full pipeline with a stalled output takes no new word.
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready && in_valid && in_ready
		##1 out_valid && !out_ready && in_valid && in_ready
		##1 out_valid && !out_ready |-> !in_ready)
		else $error("word accepted into a full pipeline");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(alu_result)
			&& $stable(target_address) && $stable(dest_reg))
		else $error("stalled result word changed");

endmodule

bind mips_decode_execute_unit mdeu_checker u_mdeu_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_ready       (in_ready),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.alu_result     (alu_result),
	.dest_reg       (dest_reg),
	.reg_write      (reg_write),
	.mem_read       (mem_read),
	.mem_write      (mem_write),
	.mem_to_reg     (mem_to_reg),
	.redirect       (redirect),
	.target_address (target_address),
	.illegal        (illegal)
);

// ----- sim/tb.sv -----
`timescale 1ns / 1ps

module tb;

	localparam logic [5:0] OP_UNUSED = 6'h3f;
	localparam logic [5:0] FN_UNUSED = 6'h3f;
	localparam int N_RANDOM = 625;

	localparam logic [5:0] FN_LIST [12] = '{mdeu_pkg::FN_ADD, mdeu_pkg::FN_ADDU,
		mdeu_pkg::FN_SUB, mdeu_pkg::FN_SUBU, mdeu_pkg::FN_AND, mdeu_pkg::FN_OR,
		mdeu_pkg::FN_NOR, mdeu_pkg::FN_SLT, mdeu_pkg::FN_SLTU, mdeu_pkg::FN_SLL,
		mdeu_pkg::FN_SRL, mdeu_pkg::FN_JR};
	localparam logic [5:0] OP_LIST [16] = '{mdeu_pkg::OP_J, mdeu_pkg::OP_JAL,
		mdeu_pkg::OP_BEQ, mdeu_pkg::OP_BNE, mdeu_pkg::OP_ADDI, mdeu_pkg::OP_ADDIU,
		mdeu_pkg::OP_SLTI, mdeu_pkg::OP_SLTIU, mdeu_pkg::OP_ANDI, mdeu_pkg::OP_ORI,
		mdeu_pkg::OP_LUI, mdeu_pkg::OP_LW, mdeu_pkg::OP_SW, mdeu_pkg::OP_LL,
		mdeu_pkg::OP_BEQ, mdeu_pkg::OP_BNE};

	typedef struct packed {
		logic [31:0] alu_result;
		logic [4:0]  dest_reg;
		logic        reg_write;
		logic        mem_read;
		logic        mem_write;
		logic        mem_to_reg;
		logic        redirect;
		logic [31:0] target_address;
		logic        illegal;
	} exec_word_t;

	class exec_board;
		exec_word_t expected_words[$];
		int accepted;
		int errors;
		int reported;

		function exec_word_t decode_execute(logic [31:0] ins, logic [31:0] a,
				logic [31:0] b, logic [31:0] npc);
			exec_word_t r;
			logic [31:0] zimm;
			logic [31:0] simm;
			logic [31:0] addr;
			logic bad;
			r = '0;
			bad = 1'b0;
			zimm = {16'h0000, ins[15:0]};
			simm = {{16{ins[15]}}, ins[15:0]};
			addr = a + simm;
			r.dest_reg = ins[20:16];
			case (ins[31:26])
				mdeu_pkg::OP_SPECIAL: begin
					r.dest_reg = ins[15:11];
					r.reg_write = 1'b1;
					case (ins[5:0])
						mdeu_pkg::FN_ADD, mdeu_pkg::FN_ADDU: r.alu_result = a + b;
						mdeu_pkg::FN_SUB, mdeu_pkg::FN_SUBU: r.alu_result = a - b;
						mdeu_pkg::FN_AND: r.alu_result = a & b;
						mdeu_pkg::FN_OR: r.alu_result = a | b;
						mdeu_pkg::FN_NOR: r.alu_result = ~(a | b);
						mdeu_pkg::FN_SLT: r.alu_result = {31'b0, $signed(a) < $signed(b)};
						mdeu_pkg::FN_SLTU: r.alu_result = {31'b0, a < b};
						mdeu_pkg::FN_SLL: r.alu_result = b << ins[10:6];
						mdeu_pkg::FN_SRL: r.alu_result = b >> ins[10:6];
						mdeu_pkg::FN_JR: begin
							r.reg_write = 1'b0;
							r.redirect = 1'b1;
							r.target_address = a;
						end
						default: bad = 1'b1;
					endcase
				end
				mdeu_pkg::OP_ADDI, mdeu_pkg::OP_ADDIU: begin
					r.reg_write = 1'b1;
					r.alu_result = addr;
				end
				mdeu_pkg::OP_ANDI: begin
					r.reg_write = 1'b1;
					r.alu_result = a & zimm;
				end
				mdeu_pkg::OP_ORI: begin
					r.reg_write = 1'b1;
					r.alu_result = a | zimm;
				end
				mdeu_pkg::OP_SLTI: begin
					r.reg_write = 1'b1;
					r.alu_result = {31'b0, $signed(a) < $signed(simm)};
				end
				mdeu_pkg::OP_SLTIU: begin
					r.reg_write = 1'b1;
					r.alu_result = {31'b0, a < simm};
				end
				mdeu_pkg::OP_LUI: begin
					r.reg_write = 1'b1;
					r.alu_result = {ins[15:0], 16'h0000};
				end
				mdeu_pkg::OP_LW, mdeu_pkg::OP_LL: begin
					r.reg_write = 1'b1;
					r.mem_read = 1'b1;
					r.mem_to_reg = 1'b1;
					r.alu_result = addr >> 2;
				end
				mdeu_pkg::OP_SW: begin
					r.mem_write = 1'b1;
					r.alu_result = addr >> 2;
				end
				mdeu_pkg::OP_BEQ, mdeu_pkg::OP_BNE: begin
					if ((ins[31:26] == mdeu_pkg::OP_BEQ) == (a == b)) begin
						r.redirect = 1'b1;
						r.target_address = npc + (simm << 2);
					end
				end
				mdeu_pkg::OP_J, mdeu_pkg::OP_JAL: begin
					r.redirect = 1'b1;
					r.target_address = {npc[31:28], ins[25:0], 2'b00};
				end
				default: bad = 1'b1;
			endcase
			if (bad) begin
				r = '0;
				r.illegal = 1'b1;
			end
			return r;
		endfunction

		function string show(exec_word_t w);
			return $sformatf("alu=%h dest=%0d rw=%b mr=%b mw=%b m2r=%b redir=%b tgt=%h ill=%b",
				w.alu_result, w.dest_reg, w.reg_write, w.mem_read, w.mem_write,
				w.mem_to_reg, w.redirect, w.target_address, w.illegal);
		endfunction

		function void note_instruction(logic [31:0] ins, logic [31:0] a, logic [31:0] b,
				logic [31:0] npc);
			expected_words.push_back(decode_execute(ins, a, b, npc));
			accepted++;
		endfunction

		function void check_result(exec_word_t got);
			exec_word_t want;
			if (expected_words.size() == 0) begin
				errors++;
				if (reported < 10) begin
					reported++;
					$display("unexpected result word: %s", show(got));
				end
				return;
			end
			want = expected_words.pop_front();
			if (got.alu_result !== want.alu_result || got.dest_reg !== want.dest_reg ||
					got.reg_write !== want.reg_write || got.mem_read !== want.mem_read ||
					got.mem_write !== want.mem_write || got.mem_to_reg !== want.mem_to_reg ||
					got.redirect !== want.redirect ||
					got.target_address !== want.target_address ||
					got.illegal !== want.illegal) begin
				errors++;
				if (reported < 10) begin
					reported++;
					$display("mismatch: expected %s", show(want));
					$display("          actual   %s", show(got));
				end
			end
		endfunction

		function int pending();
			return expected_words.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [31:0] instruction;
	logic [31:0] source_value;
	logic [31:0] target_value;
	logic [31:0] next_pc;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] alu_result;
	logic [4:0]  dest_reg;
	logic        reg_write;
	logic        mem_read;
	logic        mem_write;
	logic        mem_to_reg;
	logic        redirect;
	logic [31:0] target_address;
	logic        illegal;

	exec_board board = new();

	mips_decode_execute_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.instruction(instruction),
		.source_value(source_value),
		.target_value(target_value),
		.next_pc(next_pc),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.alu_result(alu_result),
		.dest_reg(dest_reg),
		.reg_write(reg_write),
		.mem_read(mem_read),
		.mem_write(mem_write),
		.mem_to_reg(mem_to_reg),
		.redirect(redirect),
		.target_address(target_address),
		.illegal(illegal)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 2);
		else if (r < 97)
			return $urandom_range(3, 6);
		return $urandom_range(12, 30);
	endfunction

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 32'h0000_0000;
			1: return 32'hffff_ffff;
			2: return 32'h8000_0000;
			3: return 32'h7fff_ffff;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] r_word(logic [5:0] fn, logic [4:0] rd, logic [4:0] sh);
		return {mdeu_pkg::OP_SPECIAL, 5'd1, 5'd2, rd, sh, fn};
	endfunction

	function automatic logic [31:0] i_word(logic [5:0] op, logic [4:0] rt, logic [15:0] imm);
		return {op, 5'd3, rt, imm};
	endfunction

	task automatic send_word(input logic [31:0] ins, input logic [31:0] a,
			input logic [31:0] b, input logic [31:0] npc, input int gap);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		instruction <= ins;
		source_value <= a;
		target_value <= b;
		next_pc <= npc;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		board.note_instruction(ins, a, b, npc);
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		instruction = '0;
		source_value = '0;
		target_value = '0;
		next_pc = '0;
		out_ready = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#4_000_000;
		$display("tb failed");
		$finish;
	end

	initial begin
		int stall;
		int cyc;
		bit held;
		stall = 0;
		cyc = 0;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			cyc++;
			if (!held && board.accepted >= 160) begin
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (64) @(negedge clk);
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				stall--;
			end else begin
				out_ready <= 1'b1;
				if ((cyc / 256) % 3 == 2)
					stall = 0;
				else
					stall = pick_gap();
			end
		end
	end

	initial begin
		exec_word_t got;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				got.alu_result = alu_result;
				got.dest_reg = dest_reg;
				got.reg_write = reg_write;
				got.mem_read = mem_read;
				got.mem_write = mem_write;
				got.mem_to_reg = mem_to_reg;
				got.redirect = redirect;
				got.target_address = target_address;
				got.illegal = illegal;
				board.check_result(got);
			end
		end
	end

	initial begin
		logic [31:0] ins;
		logic [31:0] a;
		logic [31:0] b;
		int k;
		int gap;
		@(posedge arst_n);
		@(posedge clk);

		send_word(r_word(mdeu_pkg::FN_ADD, 5'd4, 5'd0), 32'h7fff_ffff, 32'h1, 32'h4,
			pick_gap());
		send_word(r_word(mdeu_pkg::FN_ADDU, 5'd31, 5'd0), 32'hffff_ffff, 32'h1, 32'h8,
			pick_gap());
		send_word(r_word(mdeu_pkg::FN_SUB, 5'd0, 5'd0), 32'h0, 32'h1, 32'hc, pick_gap());
		send_word(r_word(mdeu_pkg::FN_SUBU, 5'd5, 5'd0), 32'h8000_0000, 32'h1, 32'h10,
			pick_gap());
		send_word(r_word(mdeu_pkg::FN_AND, 5'd6, 5'd0), 32'hffff_ffff, 32'h0f0f_f0f0, 32'h14,
			pick_gap());
		send_word(r_word(mdeu_pkg::FN_OR, 5'd7, 5'd0), 32'h8000_0000, 32'h0000_0001, 32'h18,
			pick_gap());
		send_word(r_word(mdeu_pkg::FN_NOR, 5'd8, 5'd0), 32'h0, 32'h0, 32'h1c, pick_gap());
		send_word(r_word(mdeu_pkg::FN_SLT, 5'd9, 5'd0), 32'h8000_0000, 32'h7fff_ffff, 32'h20,
			pick_gap());
		send_word(r_word(mdeu_pkg::FN_SLTU, 5'd10, 5'd0), 32'h8000_0000, 32'h7fff_ffff,
			32'h24, pick_gap());
		send_word(r_word(mdeu_pkg::FN_SLL, 5'd11, 5'd31), 32'h0, 32'hffff_ffff, 32'h28,
			pick_gap());
		send_word(r_word(mdeu_pkg::FN_SRL, 5'd12, 5'd31), 32'h0, 32'hffff_ffff, 32'h2c,
			pick_gap());
		send_word(r_word(mdeu_pkg::FN_JR, 5'd13, 5'd0), 32'hffff_fffc, 32'h0, 32'h30,
			pick_gap());
		send_word(i_word(mdeu_pkg::OP_ADDI, 5'd14, 16'h8000), 32'h0, 32'h0, 32'h34,
			pick_gap());
		send_word(i_word(mdeu_pkg::OP_ADDIU, 5'd15, 16'h7fff), 32'hffff_ffff, 32'h0, 32'h38,
			pick_gap());
		send_word(i_word(mdeu_pkg::OP_ANDI, 5'd16, 16'hffff), 32'hffff_ffff, 32'h0, 32'h3c,
			pick_gap());
		send_word(i_word(mdeu_pkg::OP_ORI, 5'd17, 16'h8001), 32'h0, 32'h0, 32'h40,
			pick_gap());
		send_word(i_word(mdeu_pkg::OP_SLTI, 5'd18, 16'h0000), 32'hffff_ffff, 32'h0, 32'h44,
			pick_gap());
		send_word(i_word(mdeu_pkg::OP_SLTIU, 5'd19, 16'h8000), 32'h0, 32'h0, 32'h48,
			pick_gap());
		send_word(i_word(mdeu_pkg::OP_LUI, 5'd20, 16'hffff), 32'h0, 32'h0, 32'h4c,
			pick_gap());
		send_word(i_word(mdeu_pkg::OP_LW, 5'd21, 16'hffff), 32'h3, 32'h0, 32'h50,
			pick_gap());
		send_word(i_word(mdeu_pkg::OP_LL, 5'd22, 16'h8000), 32'h0, 32'h0, 32'h54,
			pick_gap());
		send_word(i_word(mdeu_pkg::OP_SW, 5'd23, 16'h7fff), 32'hffff_ffff, 32'h0, 32'h58,
			pick_gap());
		send_word(i_word(mdeu_pkg::OP_BEQ, 5'd24, 16'h8000), 32'h5, 32'h5, 32'h0,
			pick_gap());
		send_word(i_word(mdeu_pkg::OP_BNE, 5'd25, 16'h7fff), 32'h5, 32'h5, 32'hffff_fffc,
			pick_gap());
		send_word({mdeu_pkg::OP_J, 26'h3ff_ffff}, 32'h0, 32'h0, 32'hf000_0000, pick_gap());
		send_word({mdeu_pkg::OP_JAL, 26'h0}, 32'h0, 32'h0, 32'hffff_ffff, pick_gap());
		send_word(i_word(OP_UNUSED, 5'd31, 16'hffff), 32'hffff_ffff, 32'h1, 32'h4, pick_gap());
		send_word(r_word(FN_UNUSED, 5'd31, 5'd31), 32'h1, 32'h2, 32'h8, pick_gap());

		for (int i = 0; i < N_RANDOM; i++) begin
			ins = $urandom;
			k = $urandom_range(0, 99);
			if (k >= 10 && k < 45) begin
				ins[31:26] = mdeu_pkg::OP_SPECIAL;
				ins[5:0] = ($urandom_range(0, 19) == 0) ? 6'($urandom) :
					FN_LIST[$urandom_range(0, 11)];
			end else if (k >= 45) begin
				ins[31:26] = OP_LIST[$urandom_range(0, 15)];
			end
			a = pick_value();
			b = ($urandom_range(0, 3) == 0) ? a : pick_value();
			if ((i >= 130 && i < 280) || (i / 64) % 4 == 3)
				gap = 0;
			else
				gap = pick_gap();
			send_word(ins, a, b, pick_value(), gap);
		end
		@(negedge clk);
		in_valid <= 1'b0;

		while (board.pending() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
		if (board.errors == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/core/mdeu_pkg.sv
rtl/core/mips_decode_execute_unit.sv
rtl/core/mdeu_checker.sv
sim/tb.sv
